// File: design/aging_priority_preemptive_scheduler_top_assert.svh
// Assertion macros for the aging priority scheduler.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef AGING_PRIORITY_PREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH
`define AGING_PRIORITY_PREEMPTIVE_SCHEDULER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define APPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define APPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APPS_ASSERT_IMP(lbl, ante, cons, msg)
`define APPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/apps_pkg.sv
// Shared types and constants of the aging priority scheduler.
// No dependencies.
`default_nettype none
package apps_pkg;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TW = 16;
  localparam int PW = 12;
  localparam logic [PW-1:0] PRI_MAX = 12'd4095;
  localparam logic [4:0] LIMIT_RST = 5'd20;
  localparam logic [15:0] PERIOD_RST = 16'd10;

  typedef enum logic {
    REG_QUEUE_LIMIT  = 1'b0,
    REG_AGING_PERIOD = 1'b1
  } apps_reg_e;

  typedef struct packed {
    logic [TW-1:0] arrival;
    logic [TW-1:0] burst;
    logic [PW-1:0] prio;
  } apps_entry_t;

  typedef struct packed {
    logic load;
    logic finish;
    logic scan_rd;
    logic div_start;
    logic compare;
    logic push_pre;
    logic dispatch;
    logic shift_rd;
    logic shift_wr;
    logic emit;
  } apps_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic div_done;
    logic have_pick;
    logic shift_more;
  } apps_sts_t;
endpackage
`default_nettype wire

// File: design/apps_div.sv
// Restoring 16-bit divider, one quotient bit per cycle.
// Depends on apps_pkg.
`default_nettype none
module apps_div import apps_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [TW-1:0] dividend_i,
  input  wire logic [TW-1:0] divisor_i,
  output logic               done_o,
  output logic [TW-1:0]      quotient_o
);
  localparam int CNTW = $clog2(TW + 1);
  logic [TW:0]     shifted, diff;
  logic [TW-1:0]   rem_q, quo_q, dvs_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;

  assign shifted = {rem_q, quo_q[TW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(TW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNTW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_q <= diff[TW-1:0];
        quo_q <= {quo_q[TW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[TW-1:0];
        quo_q <= {quo_q[TW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// File: design/apps_ctrl.sv
// Sequencer of one scheduler tick: finish, append, scan, preempt, dispatch, shift.
// Depends on apps_pkg.
`default_nettype none
module apps_ctrl import apps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  apps_sts_t      sts_i,
  output apps_cmd_t      cmd_o,
  output logic           busy,
  output logic           done_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIN   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DIVST = 4'd3;
  localparam logic [3:0] S_DIVW  = 4'd4;
  localparam logic [3:0] S_PRE   = 4'd5;
  localparam logic [3:0] S_DISP  = 4'd6;
  localparam logic [3:0] S_SHRD  = 4'd7;
  localparam logic [3:0] S_SHWR  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_RD;
      end
      S_RD: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_DIVST;
        end else begin
          state_d = S_PRE;
        end
      end
      S_DIVST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.compare = 1'b1;
          state_d       = S_RD;
        end
      end
      S_PRE: begin
        if (sts_i.have_pick) begin
          cmd_o.push_pre = 1'b1;
          state_d        = S_DISP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DISP: begin
        cmd_o.dispatch = 1'b1;
        state_d        = S_SHRD;
      end
      S_SHRD: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = sts_i.shift_more ? S_SHWR : S_OUT;
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHRD;
      end
      S_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.emit;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
endmodule
`default_nettype wire

// File: design/apps_dp.sv
// Datapath: ready queue memory, running job, configuration and result registers.
// Depends on apps_pkg and apps_div.
`default_nettype none
module apps_dp import apps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  apps_cmd_t          cmd_i,
  output apps_sts_t          sts_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_addr_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          job_valid_i,
  input  wire logic [7:0]    job_priority_i,
  input  wire logic [TW-1:0] job_burst_i,
  output logic               job_finished_o,
  output logic               arrival_lost_o,
  output logic               dispatched_o,
  output logic               preempted_o,
  output logic               preempt_lost_o,
  output logic [PW-1:0]      dispatch_priority_o,
  output logic [5:0]         queue_count_o,
  output logic               cpu_busy_o
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = (CW > 6) ? CW + 1 : 7;
  localparam logic [KW-1:0] DEPTH_K = KW'(QUEUE_DEPTH);

  apps_entry_t mem [QUEUE_DEPTH];
  apps_entry_t rd_q, wr_data;
  logic        wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic        rd_en;

  logic [4:0]    limit_q;
  logic [15:0]   period_q;
  logic [CW-1:0] count_q, idx_q, pick_q;
  logic          idle_q, pick_valid_q;
  logic [TW-1:0] run_start_q, run_rem_q, tick_q, best_burst_q;
  logic [PW-1:0] run_pri_q, best_q;
  logic          jv_q;
  logic [7:0]    jp_q;
  logic [TW-1:0] jb_q;
  logic          fin_q, alost_q, pre_q, plost_q, disp_q;

  logic [TW-1:0] elapsed, quot;
  logic [KW-1:0] count_k, idx1_k;
  logic          arr_ok, pre_ok, div_done, cand;
  logic [TW:0]   aged_sum;
  logic [PW-1:0] aged;

  assign elapsed = tick_q - run_start_q;
  assign count_k = KW'(count_q);
  assign idx1_k  = KW'(idx_q) + KW'(1);
  assign arr_ok  = (count_k < KW'(limit_q)) && (count_k < DEPTH_K);
  assign pre_ok  = (count_k < (KW'(limit_q) + KW'(1))) && (count_k < DEPTH_K);

  apps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (tick_q - rd_q.arrival),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Aged priority of the entry just read, saturated.
  always_comb begin
    aged_sum = {{(TW + 1 - PW){1'b0}}, rd_q.prio};
    if (period_q != '0) aged_sum = aged_sum + {1'b0, quot};
    aged = (aged_sum > (TW + 1)'(PRI_MAX)) ? PRI_MAX : aged_sum[PW-1:0];
  end
  assign cand = idle_q || (aged > run_pri_q);

  // Write and read port select.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IW-1:0];
    wr_data = '{arrival: tick_q, burst: jb_q, prio: PW'(jp_q)};
    rd_en   = 1'b0;
    rd_addr = idx_q[IW-1:0];
    if (cmd_i.finish) begin
      wr_en = jv_q && arr_ok;
    end else if (cmd_i.push_pre) begin
      wr_en   = !idle_q && pre_ok;
      wr_data = '{arrival: tick_q, burst: run_rem_q - elapsed, prio: run_pri_q};
    end else if (cmd_i.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_q[IW-1:0];
      wr_data = rd_q;
    end
    if (cmd_i.scan_rd) begin
      rd_en = 1'b1;
    end else if (cmd_i.shift_rd) begin
      rd_en   = sts_o.shift_more;
      rd_addr = idx1_k[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      jv_q <= job_valid_i;
      jp_q <= job_priority_i;
      jb_q <= job_burst_i;
    end
    if (cmd_i.compare && cand && (!pick_valid_q || aged > best_q)) begin
      pick_q       <= idx_q;
      best_q       <= aged;
      best_burst_q <= rd_q.burst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RST;
      period_q     <= PERIOD_RST;
      count_q      <= '0;
      idx_q        <= '0;
      idle_q       <= 1'b1;
      pick_valid_q <= 1'b0;
      run_start_q  <= '0;
      run_rem_q    <= '0;
      run_pri_q    <= '0;
      tick_q       <= '0;
      fin_q        <= 1'b0;
      alost_q      <= 1'b0;
      pre_q        <= 1'b0;
      plost_q      <= 1'b0;
      disp_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (apps_reg_e'(cfg_addr_i))
          REG_QUEUE_LIMIT:  limit_q  <= cfg_wdata_i[4:0];
          REG_AGING_PERIOD: period_q <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.finish) begin
        fin_q        <= !idle_q && (elapsed >= run_rem_q);
        if (!idle_q && (elapsed >= run_rem_q)) idle_q <= 1'b1;
        alost_q      <= jv_q && !arr_ok;
        if (jv_q && arr_ok) count_q <= count_q + 1'b1;
        idx_q        <= '0;
        pick_valid_q <= 1'b0;
        pre_q        <= 1'b0;
        plost_q      <= 1'b0;
        disp_q       <= 1'b0;
      end
      if (cmd_i.compare) begin
        if (cand) pick_valid_q <= 1'b1;
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.push_pre && !idle_q) begin
        pre_q   <= 1'b1;
        plost_q <= !pre_ok;
        if (pre_ok) count_q <= count_q + 1'b1;
      end
      if (cmd_i.dispatch) begin
        idle_q      <= 1'b0;
        run_start_q <= tick_q;
        run_pri_q   <= best_q;
        run_rem_q   <= best_burst_q;
        disp_q      <= 1'b1;
        idx_q       <= pick_q;
      end
      if (cmd_i.shift_rd && !sts_o.shift_more) count_q <= count_q - 1'b1;
      if (cmd_i.shift_wr) idx_q <= idx_q + 1'b1;
      if (cmd_i.emit) tick_q <= tick_q + 1'b1;
    end
  end

  // Result word, captured once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_finished_o      <= 1'b0;
      arrival_lost_o      <= 1'b0;
      dispatched_o        <= 1'b0;
      preempted_o         <= 1'b0;
      preempt_lost_o      <= 1'b0;
      dispatch_priority_o <= '0;
      queue_count_o       <= '0;
      cpu_busy_o          <= 1'b0;
    end else if (cmd_i.emit) begin
      job_finished_o      <= fin_q;
      arrival_lost_o      <= alost_q;
      dispatched_o        <= disp_q;
      preempted_o         <= pre_q;
      preempt_lost_o      <= plost_q;
      dispatch_priority_o <= idle_q ? '0 : run_pri_q;
      queue_count_o       <= 6'(count_q);
      cpu_busy_o          <= !idle_q;
    end
  end

  assign sts_o.scan_more  = (idx_q < count_q);
  assign sts_o.div_done   = div_done;
  assign sts_o.have_pick  = pick_valid_q;
  assign sts_o.shift_more = (idx1_k < count_k);
endmodule
`default_nettype wire

// File: design/aging_priority_preemptive_scheduler_top.sv
// Top level of the aging priority preemptive scheduler.
// Depends on apps_pkg, apps_ctrl, apps_dp and the assertion macro header.
`default_nettype none
`include "aging_priority_preemptive_scheduler_top_assert.svh"
// Each accepted word is one scheduler tick. A tick is taken when start is high and busy is
// low; its result word is held on the result ports and marked by result_valid_o for exactly
// one cycle, and the receiver cannot stall it. A tick with N queued entries keeps the block
// busy for the scan (one memory read, a divider start and a wait on the bit-serial division
// by the aging period per entry) plus, when a job is dispatched, the dispatch and a read
// and a write per entry shifted down behind the removed one. The bit-serial divider and the
// queue memory, read one entry at a time, set a tick's length. Configuration writes are
// taken at any edge with cfg_we_i high and must only be issued while busy is low.
module aging_priority_preemptive_scheduler_top import apps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_addr_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          job_valid_i,
  input  wire logic [7:0]    job_priority_i,
  input  wire logic [TW-1:0] job_burst_i,
  output logic               result_valid_o,
  output logic               job_finished_o,
  output logic               arrival_lost_o,
  output logic               dispatched_o,
  output logic               preempted_o,
  output logic               preempt_lost_o,
  output logic [PW-1:0]      dispatch_priority_o,
  output logic [5:0]         queue_count_o,
  output logic               cpu_busy_o
);
  apps_cmd_t cmd;
  apps_sts_t sts;

  // The controller only sequences; all state of the scheduler lives in the datapath.
  apps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (result_valid_o)
  );

  apps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .job_valid_i         (job_valid_i),
    .job_priority_i      (job_priority_i),
    .job_burst_i         (job_burst_i),
    .job_finished_o      (job_finished_o),
    .arrival_lost_o      (arrival_lost_o),
    .dispatched_o        (dispatched_o),
    .preempted_o         (preempted_o),
    .preempt_lost_o      (preempt_lost_o),
    .dispatch_priority_o (dispatch_priority_o),
    .queue_count_o       (queue_count_o),
    .cpu_busy_o          (cpu_busy_o)
  );

  // A result word is shown only once the tick has fully completed.
  `APPS_ASSERT_IMP(a_done_idle, result_valid_o, !busy, "result while busy")
  // An accepted tick always occupies the block in the next cycle.
  `APPS_ASSERT_NXT(a_start_busy, start && !busy, busy, "tick not started")
  // A preemption always comes with a dispatch.
  `APPS_ASSERT_IMP(a_pre_disp, result_valid_o && preempted_o, dispatched_o, "preempt alone")
  // An idle CPU reports zero priority.
  `APPS_ASSERT_IMP(a_idle_pri, result_valid_o && !cpu_busy_o, dispatch_priority_o == '0,
    "idle CPU with priority")
endmodule
`default_nettype wire
